@@ src/tli_pkg.sv @@
`default_nettype none
package tli_pkg;

    // Port width of every coordinate; only the low CW bits carry the value.
    localparam int IO_W = 32;
    localparam int CW   = 32;
    // Line coefficients a and b
    localparam int AW   = CW + 1;
    // Endpoint products and the coefficient c
    localparam int PW   = 2 * CW;
    localparam int CCW  = PW + 1;
    // Partial products of c split into a high and a low half
    localparam int PPW  = 2 * AW;
    // Determinant and numerators
    localparam int MW   = PPW + 1;
    localparam int NW   = MW + CW;

    typedef struct packed {
        logic [NW-1:0] nx_mag;
        logic [NW-1:0] ny_mag;
        logic [MW-1:0] m_mag;
        logic          x_neg;
        logic          y_neg;
        logic          par;
    } t_quot_req;

    typedef struct packed {
        logic [NW-1:0] rx;
        logic [NW-1:0] ry;
        logic [MW-1:0] m_mag;
        logic [CW-1:0] qx;
        logic [CW-1:0] qy;
        logic          ovf_x;
        logic          ovf_y;
        logic          x_neg;
        logic          y_neg;
        logic          par;
    } t_div_st;

endpackage
`default_nettype wire

@@ src/two_line_intersection.sv @@
`default_nettype none
// Channel   Direction  Handshake          Beat payload
// input     in         i_valid / o_stall  two lines as eight endpoint coordinates
// output    out        o_valid / i_stall  cross_x, cross_y, parallel, saturated
//
// One beat enters per cycle while o_stall is low; the pipeline is six multiply/add
// stages, a range check stage, one restoring divide stage per quotient bit and
// the output register.
// Reset clears only the valid bits; data registers are left as they are.
// A stall at the output while o_valid is high freezes the whole pipeline and raises o_stall.
module two_line_intersection (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [tli_pkg::IO_W-1:0]    i_first_start_x,
    input  logic [tli_pkg::IO_W-1:0]    i_first_start_y,
    input  logic [tli_pkg::IO_W-1:0]    i_first_end_x,
    input  logic [tli_pkg::IO_W-1:0]    i_first_end_y,
    input  logic [tli_pkg::IO_W-1:0]    i_second_start_x,
    input  logic [tli_pkg::IO_W-1:0]    i_second_start_y,
    input  logic [tli_pkg::IO_W-1:0]    i_second_end_x,
    input  logic [tli_pkg::IO_W-1:0]    i_second_end_y,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [tli_pkg::IO_W-1:0]    o_cross_x,
    output logic [tli_pkg::IO_W-1:0]    o_cross_y,
    output logic                        o_parallel,
    output logic                        o_saturated
);
    import tli_pkg::*;

    logic      en;
    logic      front_vld, div_vld;
    t_quot_req req;
    t_div_st   st;

    logic                 r_vld;
    logic [IO_W-1:0]      r_x, r_y;
    logic                 r_par, r_sat;

    logic                 clip_x, clip_y;
    logic signed [CW-1:0] n_vx, n_vy;

    // Advance everything unless the held result is refused.
    assign en      = !(r_vld && i_stall);
    assign o_stall = !en;

    tli_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_sx1   (i_first_start_x[CW-1:0]),
        .i_sy1   (i_first_start_y[CW-1:0]),
        .i_ex1   (i_first_end_x[CW-1:0]),
        .i_ey1   (i_first_end_y[CW-1:0]),
        .i_sx2   (i_second_start_x[CW-1:0]),
        .i_sy2   (i_second_start_y[CW-1:0]),
        .i_ex2   (i_second_end_x[CW-1:0]),
        .i_ey2   (i_second_end_y[CW-1:0]),
        .o_valid (front_vld),
        .o_req   (req)
    );

    tli_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_vld),
        .i_req   (req),
        .o_valid (div_vld),
        .o_st    (st)
    );

    // Clip to CW signed bits: a positive quotient may reach the largest
    // positive value, a negative one may reach one step further.
    always_comb begin
        clip_x = st.ovf_x ||
                 (!st.x_neg && st.qx[CW-1]) ||
                 (st.x_neg && (st.qx > {1'b1, {(CW-1){1'b0}}}));
        clip_y = st.ovf_y ||
                 (!st.y_neg && st.qy[CW-1]) ||
                 (st.y_neg && (st.qy > {1'b1, {(CW-1){1'b0}}}));
        if (clip_x) begin
            n_vx = st.x_neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end else begin
            n_vx = st.x_neg ? -st.qx : st.qx;
        end
        if (clip_y) begin
            n_vy = st.y_neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end else begin
            n_vy = st.y_neg ? -st.qy : st.qy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= div_vld;
        end
    end

    // Parallel lines return zero coordinates and no clip.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_par <= st.par;
            r_sat <= !st.par && (clip_x || clip_y);
            r_x   <= st.par ? '0 : IO_W'(n_vx);
            r_y   <= st.par ? '0 : IO_W'(n_vy);
        end
    end

    assign o_valid     = r_vld;
    assign o_cross_x   = r_x;
    assign o_cross_y   = r_y;
    assign o_parallel  = r_par;
    assign o_saturated = r_sat;

endmodule
`default_nettype wire

@@ src/tli_front.sv @@
`default_nettype none
module tli_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [tli_pkg::CW-1:0] i_sx1,
    input  logic signed [tli_pkg::CW-1:0] i_sy1,
    input  logic signed [tli_pkg::CW-1:0] i_ex1,
    input  logic signed [tli_pkg::CW-1:0] i_ey1,
    input  logic signed [tli_pkg::CW-1:0] i_sx2,
    input  logic signed [tli_pkg::CW-1:0] i_sy2,
    input  logic signed [tli_pkg::CW-1:0] i_ex2,
    input  logic signed [tli_pkg::CW-1:0] i_ey2,
    output logic                          o_valid,
    output tli_pkg::t_quot_req            o_req
);
    import tli_pkg::*;

    function automatic logic signed [NW-1:0] fuse_pp(input logic signed [PPW-1:0] h,
                                                      input logic signed [PPW-1:0] l);
        fuse_pp = (NW'(h) <<< CW) + NW'(l);
    endfunction

    logic [5:0] r_vld;

    // stage 1: coefficients a, b and endpoint products
    logic signed [AW-1:0] r_a1, r_b1, r_a2, r_b2;
    logic signed [PW-1:0] r_p1, r_q1, r_p2, r_q2;
    // stage 2: c and determinant products
    logic signed [AW-1:0]  r2_a1, r2_b1, r2_a2, r2_b2;
    logic signed [CCW-1:0] r_c1, r_c2;
    logic signed [PPW-1:0] r_ab, r_ba;
    // stage 3: determinant and numerator partial products
    logic signed [MW-1:0]  r3_m;
    logic signed [PPW-1:0] r_xh0, r_xl0, r_xh1, r_xl1, r_yh0, r_yl0, r_yh1, r_yl1;
    // stage 4: full numerator products
    logic signed [MW-1:0]  r4_m;
    logic signed [NW-1:0]  r_x0, r_x1, r_y0, r_y1;
    // stage 5: numerators
    logic signed [MW-1:0]  r5_m;
    logic signed [NW-1:0]  r_nx, r_ny;
    // stage 6: magnitudes and signs
    t_quot_req r_req;

    localparam int SWH = CCW - CW;
    logic signed [SWH-1:0] n_c1h, n_c2h;
    logic signed [AW-1:0]  n_c1l, n_c2l;

    assign n_c1h = r_c1[CCW-1:CW];
    assign n_c2h = r_c2[CCW-1:CW];
    assign n_c1l = {1'b0, r_c1[CW-1:0]};
    assign n_c2l = {1'b0, r_c2[CW-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a1 <= {i_ey1[CW-1], i_ey1} - {i_sy1[CW-1], i_sy1};
            r_b1 <= {i_sx1[CW-1], i_sx1} - {i_ex1[CW-1], i_ex1};
            r_a2 <= {i_ey2[CW-1], i_ey2} - {i_sy2[CW-1], i_sy2};
            r_b2 <= {i_sx2[CW-1], i_sx2} - {i_ex2[CW-1], i_ex2};
            r_p1 <= i_ex1 * i_sy1;
            r_q1 <= i_sx1 * i_ey1;
            r_p2 <= i_ex2 * i_sy2;
            r_q2 <= i_sx2 * i_ey2;

            r2_a1 <= r_a1;
            r2_b1 <= r_b1;
            r2_a2 <= r_a2;
            r2_b2 <= r_b2;
            r_c1  <= {r_p1[PW-1], r_p1} - {r_q1[PW-1], r_q1};
            r_c2  <= {r_p2[PW-1], r_p2} - {r_q2[PW-1], r_q2};
            r_ab  <= r_a1 * r_b2;
            r_ba  <= r_a2 * r_b1;

            r3_m  <= {r_ab[PPW-1], r_ab} - {r_ba[PPW-1], r_ba};
            r_xh0 <= n_c2h * r2_b1;
            r_xl0 <= n_c2l * r2_b1;
            r_xh1 <= n_c1h * r2_b2;
            r_xl1 <= n_c1l * r2_b2;
            r_yh0 <= n_c1h * r2_a2;
            r_yl0 <= n_c1l * r2_a2;
            r_yh1 <= n_c2h * r2_a1;
            r_yl1 <= n_c2l * r2_a1;

            r4_m <= r3_m;
            r_x0 <= fuse_pp(r_xh0, r_xl0);
            r_x1 <= fuse_pp(r_xh1, r_xl1);
            r_y0 <= fuse_pp(r_yh0, r_yl0);
            r_y1 <= fuse_pp(r_yh1, r_yl1);

            r5_m <= r4_m;
            r_nx <= r_x0 - r_x1;
            r_ny <= r_y0 - r_y1;

            r_req.nx_mag <= r_nx[NW-1] ? -r_nx : r_nx;
            r_req.ny_mag <= r_ny[NW-1] ? -r_ny : r_ny;
            r_req.m_mag  <= r5_m[MW-1] ? -r5_m : r5_m;
            r_req.x_neg  <= r_nx[NW-1] ^ r5_m[MW-1];
            r_req.y_neg  <= r_ny[NW-1] ^ r5_m[MW-1];
            r_req.par    <= (r5_m == '0);
        end
    end

    assign o_valid = r_vld[5];
    assign o_req   = r_req;

endmodule
`default_nettype wire

@@ src/tli_divider.sv @@
`default_nettype none
module tli_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  tli_pkg::t_quot_req i_req,
    output logic               o_valid,
    output tli_pkg::t_div_st   o_st
);
    import tli_pkg::*;

    t_div_st r_st  [0:CW];
    logic    r_vld [0:CW];

    // Stage 0: a quotient of 2^CW or more saturates whatever the sign.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0].rx    <= i_req.nx_mag;
            r_st[0].ry    <= i_req.ny_mag;
            r_st[0].m_mag <= i_req.m_mag;
            r_st[0].qx    <= '0;
            r_st[0].qy    <= '0;
            r_st[0].ovf_x <= i_req.nx_mag >= {i_req.m_mag, {CW{1'b0}}};
            r_st[0].ovf_y <= i_req.ny_mag >= {i_req.m_mag, {CW{1'b0}}};
            r_st[0].x_neg <= i_req.x_neg;
            r_st[0].y_neg <= i_req.y_neg;
            r_st[0].par   <= i_req.par;
        end
    end

    // One restoring step per stage, quotient bit CW-1 first.
    for (genvar k = 0; k < CW; k++) begin : g_step
        localparam int B = CW - 1 - k;
        logic [NW-1:0] d;
        logic          gx, gy;
        t_div_st       n_st;

        assign d = NW'(r_st[k].m_mag) << B;

        always_comb begin
            n_st = r_st[k];
            gx = r_st[k].rx >= d;
            gy = r_st[k].ry >= d;
            if (gx) begin
                n_st.rx    = r_st[k].rx - d;
                n_st.qx[B] = 1'b1;
            end
            if (gy) begin
                n_st.ry    = r_st[k].ry - d;
                n_st.qy[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k+1] <= n_st;
            end
        end
    end

    assign o_valid = r_vld[CW];
    assign o_st    = r_st[CW];

endmodule
`default_nettype wire
